[rtl/core/btr_pkg.sv]
// Shared types and constants of the barycentric triangle rasterizer.
package btr_pkg;

    // Request kinds
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_STEP = 1'b1;

    // Vertex slot code that addresses no vertex
    localparam logic [1:0] SLOT_NONE = 2'd3;

    // Decoupling queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Parameter defaults
    localparam int DEF_COORD_FRAC_BITS = 4;
    localparam int DEF_WEIGHT_BITS     = 16;
    localparam int DEF_DEPTH_BITS      = 16;

    // One classified request
    typedef struct packed {
        logic               is_step;
        logic [1:0]         slot;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [15:0]        z;
    } t_item;

    // Back-end sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_SETUP,
        S_EVAL,
        S_WSTART,
        S_WDIV,
        S_DMUL,
        S_DSTART,
        S_DDIV,
        S_OUT
    } t_state;

endpackage

[rtl/core/btr_front.sv]
// Front end: accepts requests, drops loads to the unused slot, feeds the queue.
module btr_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_kind,
    input  logic [1:0]          i_vertex_slot,
    input  logic signed [15:0]  i_vert_x,
    input  logic signed [15:0]  i_vert_y,
    input  logic [15:0]         i_vert_z,
    output logic                o_push_valid,
    output btr_pkg::t_item      o_push_item,
    input  logic                i_push_ready
);
    import btr_pkg::*;

    logic  r_valid, n_valid;
    t_item r_item, n_item;
    logic  keep;

    assign o_ready      = !r_valid || i_push_ready;
    assign o_push_valid = r_valid;
    assign o_push_item  = r_item;

    // Classify: steps always go on, loads only to a real slot
    assign keep = (i_kind == KIND_STEP) || (i_vertex_slot != SLOT_NONE);

    always_comb begin
        n_valid = r_valid && !i_push_ready;
        n_item  = r_item;
        if (i_valid && o_ready && keep) begin
            n_valid        = 1'b1;
            n_item.is_step = (i_kind == KIND_STEP);
            n_item.slot    = i_vertex_slot;
            n_item.x       = i_vert_x;
            n_item.y       = i_vert_y;
            n_item.z       = i_vert_z;
        end
    end

    // Hold the staged request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_item <= n_item;
    end

endmodule

[rtl/core/btr_queue.sv]
// Short request queue that decouples the front end from the back end.
module btr_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_valid,
    input  btr_pkg::t_item  i_push_item,
    output logic            o_push_ready,
    output logic            o_pop_valid,
    output btr_pkg::t_item  o_pop_item,
    input  logic            i_pop_ready
);
    import btr_pkg::*;

    t_item                  r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wptr;
    logic [QUEUE_PTR_W-1:0] r_rptr;
    logic [QUEUE_CNT_W-1:0] r_count;
    logic                   push;
    logic                   pop;

    assign o_push_ready = (r_count != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_item   = r_mem[r_rptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= (r_wptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (pop) begin
                r_rptr <= (r_rptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            r_count <= r_count + QUEUE_CNT_W'(push) - QUEUE_CNT_W'(pop);
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_push_item;
        end
    end

endmodule

[rtl/core/btr_back.sv]
// Back end: triangle setup, edge evaluation, weight and depth division, result register.
module btr_back #(
    parameter int COORD_FRAC_BITS = btr_pkg::DEF_COORD_FRAC_BITS,
    parameter int WEIGHT_BITS     = btr_pkg::DEF_WEIGHT_BITS,
    parameter int DEPTH_BITS      = btr_pkg::DEF_DEPTH_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_pop_valid,
    input  btr_pkg::t_item      i_pop_item,
    output logic                o_pop_ready,
    output logic                o_valid,
    input  logic                i_ready,
    output logic signed [11:0]  o_pix_x,
    output logic signed [11:0]  o_pix_y,
    output logic                o_inside_res,
    output logic [15:0]         o_weight_a,
    output logic [15:0]         o_weight_b,
    output logic [15:0]         o_weight_c,
    output logic [15:0]         o_depth,
    output logic                o_last_pixel
);
    import btr_pkg::*;

    localparam int F    = COORD_FRAC_BITS;
    localparam int PXW  = 12 + F;
    localparam int MW   = (PXW > 17) ? PXW : 17;
    localparam int PW   = 2 * MW;
    localparam int AW   = PW + 2;
    localparam int DPW  = AW + 16;
    localparam int SUMW = AW + 18;
    localparam int SH   = (WEIGHT_BITS > 16) ? WEIGHT_BITS : 16;
    localparam int CW   = $clog2(SH);
    localparam logic [SH-1:0] WCAP = SH'((64'd1 << WEIGHT_BITS) - 64'd1);
    localparam logic [15:0]   ZCAP = (DEPTH_BITS >= 16) ? 16'hFFFF
                                     : 16'((64'd1 << DEPTH_BITS) - 64'd1);
    localparam int BOX_XMIN = 0;
    localparam int BOX_XMAX = 1;
    localparam int BOX_YMIN = 2;
    localparam int BOX_YMAX = 3;

    // Saturate a box limit to the pixel range
    function automatic logic signed [11:0] clamp12(input logic signed [16:0] v);
        if (v < -17'sd2048) begin
            return -12'sd2048;
        end else if (v > 17'sd2047) begin
            return 12'sd2047;
        end
        return 12'(v);
    endfunction

    t_state r_state, n_state;

    // Triangle state
    logic signed [15:0]    r_vx [3];
    logic signed [15:0]    r_vy [3];
    logic [15:0]           r_vz [3];
    logic signed [MW-1:0]  r_ea [3];
    logic signed [MW-1:0]  r_eb [3];
    logic signed [AW-1:0]  r_ec [3];
    logic signed [AW-1:0]  r_norm [3];
    logic signed [11:0]    r_box [4];
    logic signed [11:0]    r_col;
    logic signed [11:0]    r_row;

    // Sequencing and datapath
    logic [1:0]            r_k, r_j, kn;
    logic                  r_ph;
    logic signed [PW-1:0]  r_prod;
    logic signed [AW-1:0]  r_acc;
    logic signed [AW-1:0]  r_n [3];
    logic [15:0]           r_w [3];
    logic [15:0]           r_z;
    logic [DPW-1:0]        r_dprod;
    logic [SUMW-1:0]       r_sum;
    logic [AW-1:0]         r_rem;
    logic [AW-1:0]         r_dvs;
    logic [SH-1:0]         r_shin;
    logic [SH-1:0]         r_quo;
    logic [CW-1:0]         r_dcnt;

    // Result register
    logic                  r_ovalid;
    logic signed [11:0]    r_ox, r_oy;
    logic                  r_oin, r_olast;
    logic [15:0]           r_ow [3];
    logic [15:0]           r_oz;

    logic signed [15:0]    sel_xa, sel_ya, sel_xb, sel_yb, sel_xk, sel_yk;
    logic [15:0]           sel_zk;
    logic signed [MW-1:0]  m_a, m_b, px, py;
    logic signed [AW-1:0]  prod_ext, acc_new;
    logic signed [AW-1:0]  off [3];
    logic                  bad [3];
    logic                  degen, cls_inside;
    logic signed [AW-1:0]  cur_n, cur_d;
    logic [AW-1:0]         abs_n, abs_d;
    logic                  w_skip, w_cap;
    logic [AW:0]           div_t;
    logic                  div_ge;
    logic [AW-1:0]         rem_new;
    logic [SH-1:0]         quo_new;
    logic signed [15:0]    xmin, xmax, ymin, ymax;
    logic signed [11:0]    bx_min, bx_max, by_min, by_max;
    logic                  out_load, last_hit;

    assign o_pop_ready = (r_state == S_IDLE);
    assign kn          = (r_k == 2'd2) ? 2'd0 : r_k + 2'd1;
    assign out_load    = (r_state == S_OUT) && (!r_ovalid || i_ready);
    assign last_hit    = (r_col == r_box[BOX_XMAX]) && (r_row == r_box[BOX_YMAX]);

    // Select the vertices of edge r_k and its opposite vertex
    always_comb begin
        case (r_k)
            2'd0: begin
                sel_xa = r_vx[1]; sel_ya = r_vy[1];
                sel_xb = r_vx[2]; sel_yb = r_vy[2];
                sel_xk = r_vx[0]; sel_yk = r_vy[0]; sel_zk = r_vz[0];
            end
            2'd1: begin
                sel_xa = r_vx[2]; sel_ya = r_vy[2];
                sel_xb = r_vx[0]; sel_yb = r_vy[0];
                sel_xk = r_vx[1]; sel_yk = r_vy[1]; sel_zk = r_vz[1];
            end
            default: begin
                sel_xa = r_vx[0]; sel_ya = r_vy[0];
                sel_xb = r_vx[1]; sel_yb = r_vy[1];
                sel_xk = r_vx[2]; sel_yk = r_vy[2]; sel_zk = r_vz[2];
            end
        endcase
    end

    // Pick multiplier operands
    assign px = MW'(r_col) <<< F;
    assign py = MW'(r_row) <<< F;
    always_comb begin
        m_a = '0;
        m_b = '0;
        if (r_state == S_SETUP) begin
            case (r_j)
                2'd0:    begin m_a = MW'(sel_xa); m_b = MW'(sel_yb); end
                2'd1:    begin m_a = MW'(sel_xb); m_b = MW'(sel_ya); end
                2'd2:    begin m_a = r_ea[r_k];   m_b = MW'(sel_xk); end
                default: begin m_a = r_eb[r_k];   m_b = MW'(sel_yk); end
            endcase
        end else if (r_state == S_EVAL) begin
            if (r_j == 2'd0) begin
                m_a = r_ea[r_k]; m_b = px;
            end else begin
                m_a = r_eb[r_k]; m_b = py;
            end
        end
    end

    // Accumulate products; the second setup term is subtracted
    assign prod_ext = AW'(r_prod);
    assign acc_new  = (r_state == S_SETUP && r_j == 2'd1) ? r_acc - prod_ext
                                                          : r_acc + prod_ext;

    // Coverage test with the tie rule
    always_comb begin
        degen = (r_norm[0] == '0) || (r_norm[1] == '0) || (r_norm[2] == '0);
        for (int k = 0; k < 3; k++) begin
            off[k] = r_ec[k] - ((AW'(r_ea[k]) + AW'(r_eb[k])) <<< F);
            bad[k] = (r_norm[k] == '0)
                  || (r_n[k] != '0 && (r_n[k][AW-1] != r_norm[k][AW-1]))
                  || (r_n[k] == '0
                      && !((off[k] > 0 && r_norm[k] > 0) || (off[k] < 0 && r_norm[k] < 0)));
        end
        cls_inside = !(bad[0] || bad[1] || bad[2]);
    end

    // Weight classification for edge r_k
    assign cur_n  = r_n[r_k];
    assign cur_d  = r_norm[r_k];
    assign abs_n  = cur_n[AW-1] ? AW'(-cur_n) : AW'(cur_n);
    assign abs_d  = cur_d[AW-1] ? AW'(-cur_d) : AW'(cur_d);
    assign w_skip = degen || (cur_n == '0) || (cur_n[AW-1] != cur_d[AW-1]);
    assign w_cap  = (abs_n >= abs_d);

    // One restoring division step
    assign div_t   = {r_rem, r_shin[SH-1]};
    assign div_ge  = (div_t >= {1'b0, r_dvs});
    assign rem_new = div_ge ? AW'(div_t - {1'b0, r_dvs}) : AW'(div_t);
    assign quo_new = {r_quo[SH-2:0], div_ge};

    // Bounding box from the current vertices
    always_comb begin
        xmin = r_vx[0]; xmax = r_vx[0];
        ymin = r_vy[0]; ymax = r_vy[0];
        for (int k = 1; k < 3; k++) begin
            if (r_vx[k] < xmin) xmin = r_vx[k];
            if (r_vx[k] > xmax) xmax = r_vx[k];
            if (r_vy[k] < ymin) ymin = r_vy[k];
            if (r_vy[k] > ymax) ymax = r_vy[k];
        end
        bx_min = clamp12(17'(xmin) >>> F);
        bx_max = clamp12((17'(xmax) + 17'sd0 + 17'((1 << F) - 1)) >>> F);
        by_min = clamp12(17'(ymin) >>> F);
        by_max = clamp12((17'(ymax) + 17'sd0 + 17'((1 << F) - 1)) >>> F);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_pop_valid) n_state = i_pop_item.is_step ? S_EVAL : S_PREP;
            end
            S_PREP:  n_state = S_SETUP;
            S_SETUP: begin
                if (r_ph && r_j == 2'd3 && r_k == 2'd2) n_state = S_IDLE;
            end
            S_EVAL: begin
                if (r_ph && r_j == 2'd1 && r_k == 2'd2) n_state = S_WSTART;
            end
            S_WSTART: begin
                if (!(w_skip || w_cap)) begin
                    n_state = S_WDIV;
                end else if (r_k == 2'd2) begin
                    n_state = cls_inside ? S_DMUL : S_OUT;
                end
            end
            S_WDIV: begin
                if (r_dcnt == '0) begin
                    if (r_k != 2'd2) n_state = S_WSTART;
                    else             n_state = cls_inside ? S_DMUL : S_OUT;
                end
            end
            S_DMUL: begin
                if (r_ph && r_k == 2'd2) n_state = S_DSTART;
            end
            S_DSTART: n_state = S_DDIV;
            S_DDIV: begin
                if (r_dcnt == '0) n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_ovalid || i_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Triangle state and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_vx[k]   <= '0;
                r_vy[k]   <= '0;
                r_vz[k]   <= '0;
                r_ea[k]   <= '0;
                r_eb[k]   <= '0;
                r_ec[k]   <= '0;
                r_norm[k] <= '0;
            end
            for (int b = 0; b < 4; b++) begin
                r_box[b] <= '0;
            end
            r_col <= '0;
            r_row <= '0;
            r_k   <= '0;
            r_j   <= '0;
            r_ph  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    r_k  <= '0;
                    r_j  <= '0;
                    r_ph <= 1'b0;
                    if (i_pop_valid) begin
                        if (i_pop_item.is_step) begin
                            r_acc <= r_ec[0];
                        end else begin
                            r_vx[i_pop_item.slot] <= i_pop_item.x;
                            r_vy[i_pop_item.slot] <= i_pop_item.y;
                            r_vz[i_pop_item.slot] <= i_pop_item.z;
                        end
                    end
                end
                S_PREP: begin
                    r_ea[0] <= MW'(r_vy[1]) - MW'(r_vy[2]);
                    r_eb[0] <= MW'(r_vx[2]) - MW'(r_vx[1]);
                    r_ea[1] <= MW'(r_vy[2]) - MW'(r_vy[0]);
                    r_eb[1] <= MW'(r_vx[0]) - MW'(r_vx[2]);
                    r_ea[2] <= MW'(r_vy[0]) - MW'(r_vy[1]);
                    r_eb[2] <= MW'(r_vx[1]) - MW'(r_vx[0]);
                    r_box[BOX_XMIN] <= bx_min;
                    r_box[BOX_XMAX] <= bx_max;
                    r_box[BOX_YMIN] <= by_min;
                    r_box[BOX_YMAX] <= by_max;
                    r_col <= bx_min;
                    r_row <= by_min;
                    r_acc <= '0;
                end
                S_SETUP: begin
                    if (!r_ph) begin
                        r_prod <= m_a * m_b;
                        r_ph   <= 1'b1;
                    end else begin
                        r_ph <= 1'b0;
                        if (r_j == 2'd1) r_ec[r_k] <= acc_new;
                        if (r_j == 2'd3) begin
                            r_norm[r_k] <= acc_new;
                            r_acc       <= '0;
                            r_j         <= '0;
                            r_k         <= kn;
                        end else begin
                            r_acc <= acc_new;
                            r_j   <= r_j + 2'd1;
                        end
                    end
                end
                S_EVAL: begin
                    if (!r_ph) begin
                        r_prod <= m_a * m_b;
                        r_ph   <= 1'b1;
                    end else begin
                        r_ph <= 1'b0;
                        if (r_j == 2'd1) begin
                            r_n[r_k] <= acc_new;
                            r_acc    <= r_ec[kn];
                            r_j      <= '0;
                            r_k      <= kn;
                        end else begin
                            r_acc <= acc_new;
                            r_j   <= r_j + 2'd1;
                        end
                    end
                end
                S_WSTART: begin
                    r_sum <= '0;
                    r_z   <= '0;
                    r_ph  <= 1'b0;
                    if (w_skip) begin
                        r_w[r_k] <= '0;
                        r_k      <= kn;
                    end else if (w_cap) begin
                        r_w[r_k] <= WCAP[15:0];
                        r_k      <= kn;
                    end else begin
                        r_rem  <= abs_n;
                        r_dvs  <= abs_d;
                        r_shin <= '0;
                        r_quo  <= '0;
                        r_dcnt <= CW'(WEIGHT_BITS - 1);
                    end
                end
                S_WDIV: begin
                    r_rem  <= rem_new;
                    r_quo  <= quo_new;
                    r_shin <= r_shin << 1;
                    r_dcnt <= r_dcnt - 1'b1;
                    if (r_dcnt == '0) begin
                        r_w[r_k] <= quo_new[15:0];
                        r_k      <= kn;
                    end
                end
                S_DMUL: begin
                    if (!r_ph) begin
                        r_dprod <= DPW'(abs_n) * DPW'(sel_zk);
                        r_ph    <= 1'b1;
                    end else begin
                        r_sum <= r_sum + SUMW'(r_dprod);
                        r_ph  <= 1'b0;
                        r_k   <= kn;
                    end
                end
                S_DSTART: begin
                    r_rem  <= AW'(r_sum >> 16);
                    r_dvs  <= abs_d;
                    r_shin <= SH'(r_sum[15:0]) << (SH - 16);
                    r_quo  <= '0;
                    r_dcnt <= CW'(15);
                end
                S_DDIV: begin
                    r_rem  <= rem_new;
                    r_quo  <= quo_new;
                    r_shin <= r_shin << 1;
                    r_dcnt <= r_dcnt - 1'b1;
                    if (r_dcnt == '0) begin
                        r_z <= (quo_new[15:0] > ZCAP) ? ZCAP : quo_new[15:0];
                    end
                end
                S_OUT: begin
                    // Advance the scan once the result is registered
                    if (out_load) begin
                        if (r_col >= r_box[BOX_XMAX]) begin
                            r_col <= r_box[BOX_XMIN];
                            r_row <= (r_row >= r_box[BOX_YMAX]) ? r_box[BOX_YMIN]
                                                                 : r_row + 12'sd1;
                        end else begin
                            r_col <= r_col + 12'sd1;
                        end
                    end
                end
                default: begin
                    r_ph <= 1'b0;
                end
            endcase
        end
    end

    // Result register: load on a finished step, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
        if (out_load) begin
            r_ox    <= r_col;
            r_oy    <= r_row;
            r_oin   <= cls_inside;
            r_ow[0] <= r_w[0];
            r_ow[1] <= r_w[1];
            r_ow[2] <= r_w[2];
            r_oz    <= cls_inside ? r_z : 16'd0;
            r_olast <= last_hit;
        end
    end

    assign o_valid      = r_ovalid;
    assign o_pix_x      = r_ox;
    assign o_pix_y      = r_oy;
    assign o_inside_res = r_oin;
    assign o_weight_a   = r_ow[0];
    assign o_weight_b   = r_ow[1];
    assign o_weight_c   = r_ow[2];
    assign o_depth      = r_oz;
    assign o_last_pixel = r_olast;

`ifndef SYNTH
    a_col_in_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_col >= r_box[BOX_XMIN]) && (r_col <= r_box[BOX_XMAX]))
        else $error("scan column left the bounding box");

    a_row_in_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_row >= r_box[BOX_YMIN]) && (r_row <= r_box[BOX_YMAX]))
        else $error("scan row left the bounding box");

    a_rem_below_dvs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WDIV || r_state == S_DDIV) |-> (r_rem < r_dvs))
        else $error("divider remainder not below divisor");

    a_out_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> r_ovalid)
        else $error("result register lost a finished step");
`endif

endmodule

[rtl/core/barycentric_triangle_rasterizer.sv]
// Top level of the barycentric triangle rasterizer.
//
// Input channel (i_valid / o_ready): each request either loads one vertex
// (i_kind = 0, slot 0..2; slot 3 is accepted and ignored) or steps the scan
// to the next pixel of the triangle's bounding box (i_kind = 1).
// Output channel (o_valid / i_ready): one result per step request with the
// pixel, coverage flag, three weights, depth and end-of-box flag. Loads
// produce no result.
// Requests pass a front register and a two-entry queue before the back end,
// which works on one request at a time.
// In a load the setup computes twelve products on one shared multiplier. A
// step computes six products for the edge values, one bit-serial divider run
// per weight that is neither zero nor capped and, for a covered pixel,
// sixteen steps for the depth.
// Reset clears all vertices, the box and the scan position to zero.
// When the receiver stalls, the finished result waits in the output register
// while the back end goes on with loads; a further step waits in the back
// end, and the queue and front register fill before o_ready drops.
module barycentric_triangle_rasterizer #(
    parameter int COORD_FRAC_BITS = btr_pkg::DEF_COORD_FRAC_BITS,
    parameter int WEIGHT_BITS     = btr_pkg::DEF_WEIGHT_BITS,
    parameter int DEPTH_BITS      = btr_pkg::DEF_DEPTH_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_kind,
    input  logic [1:0]          i_vertex_slot,
    input  logic signed [15:0]  i_vert_x,
    input  logic signed [15:0]  i_vert_y,
    input  logic [15:0]         i_vert_z,
    output logic                o_valid,
    input  logic                i_ready,
    output logic signed [11:0]  o_pix_x,
    output logic signed [11:0]  o_pix_y,
    output logic                o_inside_res,
    output logic [15:0]         o_weight_a,
    output logic [15:0]         o_weight_b,
    output logic [15:0]         o_weight_c,
    output logic [15:0]         o_depth,
    output logic                o_last_pixel
);
    import btr_pkg::*;

    logic  push_valid, push_ready, pop_valid, pop_ready;
    t_item push_item, pop_item;

    btr_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_kind        (i_kind),
        .i_vertex_slot (i_vertex_slot),
        .i_vert_x      (i_vert_x),
        .i_vert_y      (i_vert_y),
        .i_vert_z      (i_vert_z),
        .o_push_valid  (push_valid),
        .o_push_item   (push_item),
        .i_push_ready  (push_ready)
    );

    btr_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_item  (push_item),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_item   (pop_item),
        .i_pop_ready  (pop_ready)
    );

    btr_back #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS),
        .WEIGHT_BITS     (WEIGHT_BITS),
        .DEPTH_BITS      (DEPTH_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pop_valid  (pop_valid),
        .i_pop_item   (pop_item),
        .o_pop_ready  (pop_ready),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_pix_x      (o_pix_x),
        .o_pix_y      (o_pix_y),
        .o_inside_res (o_inside_res),
        .o_weight_a   (o_weight_a),
        .o_weight_b   (o_weight_b),
        .o_weight_c   (o_weight_c),
        .o_depth      (o_depth),
        .o_last_pixel (o_last_pixel)
    );

endmodule

[tb/sv/barycentric_triangle_rasterizer_tb.sv]
// Self-checking testbench for the barycentric triangle rasterizer.
`timescale 1ns / 100ps

module barycentric_triangle_rasterizer_tb;
    import btr_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int ITEMS_PER_PHASE = 250;

    // One predicted pixel result
    typedef struct {
        logic [11:0] px;
        logic [11:0] py;
        logic        covered;
        logic [15:0] wa;
        logic [15:0] wb;
        logic [15:0] wc;
        logic [15:0] z;
        logic        last;
    } t_pixel;

    // Triangle state predictor and the queue of pixels it owes
    class pixel_scoreboard;
        longint vx[3], vy[3], vz[3], norm[3];
        longint box_x0, box_x1, box_y0, box_y1, col, row;
        t_pixel owed[$];
        int errors;

        function new();
            for (int k = 0; k < 3; k++) begin
                vx[k] = 0; vy[k] = 0; vz[k] = 0; norm[k] = 0;
            end
            box_x0 = 0; box_x1 = 0; box_y0 = 0; box_y1 = 0; col = 0; row = 0;
            errors = 0;
        endfunction

        function longint edge_val(int a, int b, longint px, longint py);
            return (vy[a] - vy[b]) * px + (vx[b] - vx[a]) * py + vx[a] * vy[b] - vx[b] * vy[a];
        endfunction

        function int sgn(longint v);
            return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
        endfunction

        function longint clamp_pix(longint v);
            return (v < -2048) ? -2048 : ((v > 2047) ? 2047 : v);
        endfunction

        function longint weight(longint n, longint d);
            longint un, ud, q;
            if (d == 0 || n == 0 || sgn(n) != sgn(d)) return 0;
            un = (n < 0) ? -n : n;
            ud = (d < 0) ? -d : d;
            q = (un <<< 16) / ud;
            return (q > 65535) ? 65535 : q;
        endfunction

        // Update the triangle on a load, or predict one pixel on a step
        function void note_request(logic kind, logic [1:0] slot, logic signed [15:0] x,
                                   logic signed [15:0] y, logic [15:0] z);
            int ea[3] = '{1, 2, 0};
            int eb[3] = '{2, 0, 1};
            longint xmin, xmax, ymin, ymax, n[3], ud, sum, zz, off;
            logic covered;
            t_pixel p;
            if (kind == KIND_LOAD) begin
                if (slot == SLOT_NONE) return;
                vx[slot] = x; vy[slot] = y; vz[slot] = z;
                xmin = vx[0]; xmax = vx[0]; ymin = vy[0]; ymax = vy[0];
                for (int k = 1; k < 3; k++) begin
                    if (vx[k] < xmin) xmin = vx[k];
                    if (vx[k] > xmax) xmax = vx[k];
                    if (vy[k] < ymin) ymin = vy[k];
                    if (vy[k] > ymax) ymax = vy[k];
                end
                box_x0 = clamp_pix(xmin >>> 4);
                box_x1 = clamp_pix(-((-xmax) >>> 4));
                box_y0 = clamp_pix(ymin >>> 4);
                box_y1 = clamp_pix(-((-ymax) >>> 4));
                for (int k = 0; k < 3; k++) norm[k] = edge_val(ea[k], eb[k], vx[k], vy[k]);
                col = box_x0;
                row = box_y0;
                return;
            end
            off = -16;
            covered = 1'b1;
            for (int k = 0; k < 3; k++) begin
                n[k] = edge_val(ea[k], eb[k], col * 16, row * 16);
                if (norm[k] == 0) covered = 1'b0;
                else begin
                    if (n[k] != 0 && sgn(n[k]) != sgn(norm[k])) covered = 1'b0;
                    // tie rule: zero weight counts only if (-1,-1) is inside this edge
                    if (n[k] == 0 && sgn(edge_val(ea[k], eb[k], off, off)) * sgn(norm[k]) <= 0)
                        covered = 1'b0;
                end
            end
            p.px = col[11:0];
            p.py = row[11:0];
            p.covered = covered;
            if (norm[0] == 0 || norm[1] == 0 || norm[2] == 0) begin
                p.wa = '0; p.wb = '0; p.wc = '0;
            end else begin
                p.wa = 16'(weight(n[0], norm[0]));
                p.wb = 16'(weight(n[1], norm[1]));
                p.wc = 16'(weight(n[2], norm[2]));
            end
            zz = 0;
            if (covered) begin
                ud = (norm[0] < 0) ? -norm[0] : norm[0];
                sum = 0;
                for (int k = 0; k < 3; k++) sum += ((n[k] < 0) ? -n[k] : n[k]) * vz[k];
                zz = sum / ud;
                if (zz > 65535) zz = 65535;
            end
            p.z = zz[15:0];
            p.last = (col == box_x1) && (row == box_y1);
            owed.push_back(p);
            // advance scan in row order, wrapping at the end of the box
            if (col >= box_x1) begin
                col = box_x0;
                row = (row >= box_y1) ? box_y0 : row + 1;
            end else begin
                col = col + 1;
            end
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $time, msg);
            errors++;
        endtask

        task cmp(string name, longint got, longint want);
            if (got != want) report($sformatf("%s got %0h want %0h", name, got, want));
        endtask

        // Compare one accepted pixel with the oldest prediction
        task check_result(logic [11:0] px, logic [11:0] py, logic covered, logic [15:0] wa,
                          logic [15:0] wb, logic [15:0] wc, logic [15:0] z, logic last);
            t_pixel p;
            if (owed.size() == 0) begin
                report("result with no request pending");
                return;
            end
            p = owed.pop_front();
            cmp("pix_x", px, p.px);
            cmp("pix_y", py, p.py);
            cmp("inside_res", covered, p.covered);
            cmp("weight_a", wa, p.wa);
            cmp("weight_b", wb, p.wb);
            cmp("weight_c", wc, p.wc);
            cmp("depth", z, p.z);
            cmp("last_pixel", last, p.last);
        endtask
    endclass

    logic i_clk, i_rst_n, i_valid, o_ready, i_kind, o_valid, i_ready;
    logic [1:0] i_vertex_slot;
    logic signed [15:0] i_vert_x, i_vert_y;
    logic [15:0] i_vert_z;
    logic signed [11:0] o_pix_x, o_pix_y;
    logic o_inside_res, o_last_pixel;
    logic [15:0] o_weight_a, o_weight_b, o_weight_c, o_depth;

    pixel_scoreboard sb;
    int send_idle, recv_idle, hold_left, sent_count, quiet_cycles;

    barycentric_triangle_rasterizer uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_kind(i_kind), .i_vertex_slot(i_vertex_slot), .i_vert_x(i_vert_x),
        .i_vert_y(i_vert_y), .i_vert_z(i_vert_z), .o_valid(o_valid), .i_ready(i_ready),
        .o_pix_x(o_pix_x), .o_pix_y(o_pix_y), .o_inside_res(o_inside_res),
        .o_weight_a(o_weight_a), .o_weight_b(o_weight_b), .o_weight_c(o_weight_c),
        .o_depth(o_depth), .o_last_pixel(o_last_pixel)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Offer one request, with random idle cycles ahead of it
    task automatic send_req(logic kind, logic [1:0] slot, logic [15:0] x, logic [15:0] y,
                            logic [15:0] z);
        if ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle);
        end
        i_valid <= 1'b1;
        i_kind <= kind;
        i_vertex_slot <= slot;
        i_vert_x <= x;
        i_vert_y <= y;
        i_vert_z <= z;
        do @(posedge i_clk); while (!o_ready);
        sb.note_request(kind, slot, x, y, z);
        sent_count++;
    endtask

    task automatic step_req();
        send_req(KIND_STEP, 2'($urandom_range(3)), 16'($urandom), 16'($urandom),
                 16'($urandom));
    endtask

    task automatic load_req(logic [1:0] slot, int x, int y, logic [15:0] z);
        send_req(KIND_LOAD, slot, x[15:0], y[15:0], z);
    endtask

    // Hold the sender until every predicted pixel has come back
    task automatic drain();
        i_valid <= 1'b0;
        while (sb.owed.size() != 0) @(posedge i_clk);
    endtask

    // Small random triangle with a random number of steps through its box, or a noise request
    task automatic random_burst();
        int bx, by, steps;
        int xs[3], ys[3];
        if ($urandom_range(9) == 0) begin
            if ($urandom_range(1)) step_req();
            else send_req(KIND_LOAD, 2'($urandom_range(3)), 16'($urandom), 16'($urandom),
                          16'($urandom));
            return;
        end
        bx = ($urandom_range(3990) - 2000) * 16;
        by = ($urandom_range(3990) - 2000) * 16;
        for (int k = 0; k < 3; k++) begin
            xs[k] = bx + $urandom_range(80);
            ys[k] = by + $urandom_range(80);
        end
        // snap to whole pixels now and then so edges pass through pixel centers
        if ($urandom_range(2) == 0)
            for (int k = 0; k < 3; k++) begin
                xs[k] = xs[k] & ~15;
                ys[k] = ys[k] & ~15;
            end
        if ($urandom_range(9) == 0) begin
            xs[2] = xs[1];
            ys[2] = ys[1];
        end
        for (int k = 0; k < 3; k++) load_req(2'(k), xs[k], ys[k], 16'($urandom));
        steps = $urandom_range(45, 1);
        for (int k = 0; k < steps; k++) step_req();
    endtask

    // Receive and check pixels; honor a requested long hold-off
    initial begin
        i_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready)
                sb.check_result(o_pix_x, o_pix_y, o_inside_res, o_weight_a, o_weight_b,
                                o_weight_c, o_depth, o_last_pixel);
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= recv_idle);
            end
        end
    end

    // Watchdog on cycles with no request or result moving
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        sb = new();
        send_idle = 18;
        recv_idle = 74;
        hold_left = 0;
        sent_count = 0;
        quiet_cycles = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_kind = KIND_LOAD;
        i_vertex_slot = 2'd0;
        i_vert_x = '0;
        i_vert_y = '0;
        i_vert_z = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset state, ignored slot, extreme box, pixel-aligned ties
        step_req();
        send_req(KIND_LOAD, SLOT_NONE, 16'hffff, 16'hffff, 16'hffff);
        step_req();
        load_req(0, -32768, -32768, 16'h0000);
        load_req(1, 32767, -32768, 16'hffff);
        load_req(2, -32768, 32767, 16'h8000);
        step_req();
        step_req();
        load_req(0, 0, 0, 16'h1234);
        load_req(1, 32, 0, 16'hffff);
        load_req(2, 0, 32, 16'h0001);
        for (int k = 0; k < 10; k++) step_req();

        // random phases with shifting idle mix
        while (sent_count < ITEMS_PER_PHASE) random_burst();
        send_idle = 74;
        recv_idle = 18;
        hold_left = 600;
        while (sent_count < 2 * ITEMS_PER_PHASE) random_burst();
        drain();
        send_idle = 0;
        recv_idle = 0;
        while (sent_count < 3 * ITEMS_PER_PHASE) random_burst();
        drain();
        repeat (200) @(posedge i_clk);

        if (sb.errors == 0 && sb.owed.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
